// File: hdl/dag_longest_path_top_macros.svh
// Assertion macros used by the checker file.
`ifndef DAG_LONGEST_PATH_TOP_MACROS_SVH
`define DAG_LONGEST_PATH_TOP_MACROS_SVH

// Clocked assertion with a synchronous active-low reset as the disable term.
`define DLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: when the antecedent holds, the consequent holds in the same cycle.
`define DLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/dlp_pkg.sv
package dlp_pkg;

    // Sizes fixed by the field widths.
    localparam int DLP_MAX_VERTICES = 16;
    localparam int DLP_MAX_EDGES    = 64;
    localparam int DLP_VW           = 4;
    localparam int DLP_CW           = 5;
    localparam int DLP_WW           = 16;
    localparam int DLP_DW           = 24;

    localparam logic [1:0] DLP_CMD_ADD = 2'd0;
    localparam logic [1:0] DLP_CMD_RUN = 2'd1;
    localparam logic [1:0] DLP_CMD_CLR = 2'd2;

    localparam logic signed [DLP_DW:0] DLP_DIST_MAX = 25'sd8388607;
    localparam logic signed [DLP_DW:0] DLP_DIST_MIN = -25'sd8388608;

    // Classified command.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_RUN,
        OP_CLR,
        OP_NOP
    } t_op;

    // One queued item.
    typedef struct packed {
        t_op                       op;
        logic [DLP_VW-1:0]         from_v;
        logic [DLP_VW-1:0]         to_v;
        logic signed [DLP_WW-1:0]  weight;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OUTER,
        S_TOP,
        S_EDGE,
        S_RINIT,
        S_RPICK,
        S_RWALK,
        S_RREL,
        S_EMIT
    } t_state;

endpackage

// File: hdl/dag_longest_path_top.sv
// An add-edge or clear item passes through the two-entry input queue and is handled in the
// back end's idle state, so such items are taken one per cycle while the back end is idle.
// A compute item is first ordered by a depth-first walk and then relaxed, then gives
// V results, one per cycle when the output is free; the back end takes no item meanwhile.
// Reset (synchronous, active low) empties every edge list, zeroes the fill count and the
// dropped flag, and sets the vertex count register to 16.
module dag_longest_path_top #(
    parameter int MAX_EDGES = dlp_pkg::DLP_MAX_EDGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [dlp_pkg::DLP_VW-1:0]        i_from_vertex,
    input  logic [dlp_pkg::DLP_VW-1:0]        i_to_vertex,
    input  logic signed [dlp_pkg::DLP_WW-1:0] i_weight,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dlp_pkg::DLP_CW-1:0]        i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dlp_pkg::DLP_VW-1:0]        o_vertex_index,
    output logic                              o_reachable,
    output logic signed [dlp_pkg::DLP_DW-1:0] o_distance,
    output logic                              o_edges_dropped,
    output logic                              o_last_result
);
    import dlp_pkg::*;

    t_item             item;
    logic              item_valid, item_ready;
    logic [DLP_CW-1:0] r_vertex_count;

    // Vertex count register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vertex_count <= DLP_CW'(DLP_MAX_VERTICES);
        else if (i_cfg_valid) r_vertex_count <= i_cfg_data;
    end

    dlp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_weight      (i_weight),
        .o_item_valid  (item_valid),
        .i_item_ready  (item_ready),
        .o_item        (item)
    );

    dlp_back #(.MAX_EDGES(MAX_EDGES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .o_item_ready    (item_ready),
        .i_item          (item),
        .i_vertex_count  (r_vertex_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_vertex_index  (o_vertex_index),
        .o_reachable     (o_reachable),
        .o_distance      (o_distance),
        .o_edges_dropped (o_edges_dropped),
        .o_last_result   (o_last_result)
    );

endmodule

// File: hdl/dlp_front.sv
module dlp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [dlp_pkg::DLP_VW-1:0]        i_from_vertex,
    input  logic [dlp_pkg::DLP_VW-1:0]        i_to_vertex,
    input  logic signed [dlp_pkg::DLP_WW-1:0] i_weight,
    output logic                              o_item_valid,
    input  logic                              i_item_ready,
    output dlp_pkg::t_item                    o_item
);
    import dlp_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op        op;
    logic       push, pop;

    // Classify the command; unknown codes are dropped here.
    always_comb begin
        unique case (i_cmd)
            DLP_CMD_ADD: op = OP_ADD;
            DLP_CMD_RUN: op = OP_RUN;
            DLP_CMD_CLR: op = OP_CLR;
            default:     op = OP_NOP;
        endcase
    end

    assign o_in_ready   = (r_cnt != 2'd2);
    assign push         = i_in_valid && o_in_ready && (op != OP_NOP);
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rp];

    // Two-entry queue towards the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= '{op: op, from_v: i_from_vertex, to_v: i_to_vertex,
                               weight: i_weight};
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: hdl/dlp_back.sv
module dlp_back #(
    parameter int MAX_EDGES = dlp_pkg::DLP_MAX_EDGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_valid,
    output logic                              o_item_ready,
    input  dlp_pkg::t_item                    i_item,
    input  logic [dlp_pkg::DLP_CW-1:0]        i_vertex_count,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dlp_pkg::DLP_VW-1:0]        o_vertex_index,
    output logic                              o_reachable,
    output logic signed [dlp_pkg::DLP_DW-1:0] o_distance,
    output logic                              o_edges_dropped,
    output logic                              o_last_result
);
    import dlp_pkg::*;

    localparam int NV = DLP_MAX_VERTICES;
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);

    // Edge store.
    logic [DLP_VW-1:0]        m_tgt [MAX_EDGES];
    logic signed [DLP_WW-1:0] m_wt  [MAX_EDGES];
    logic [EW-1:0]            m_lnk [MAX_EDGES];
    logic [DLP_VW-1:0]        r_rd_tgt;
    logic signed [DLP_WW-1:0] r_rd_wt;
    logic [EW-1:0]            r_rd_lnk;

    logic [EW-1:0]            r_head [NV];
    logic [EW-1:0]            r_fill;
    logic                     r_ovf;

    t_state                   r_state, n_state;
    logic [DLP_CW-1:0]        r_nv, r_i, r_depth, r_count, r_j;
    logic [DLP_VW-1:0]        r_start, r_u;
    logic [NV-1:0]            r_vis, r_bv;
    logic [DLP_VW-1:0]        r_stk_v [NV];
    logic [EW-1:0]            r_stk_e [NV];
    logic [DLP_VW-1:0]        r_ord [NV];
    logic signed [DLP_DW-1:0] r_bd [NV];
    logic signed [DLP_DW-1:0] r_du;
    logic [EW-1:0]            r_e;

    logic                     r_ov;
    logic [DLP_VW-1:0]        r_o_idx;
    logic                     r_o_rch, r_o_drop, r_o_last;
    logic signed [DLP_DW-1:0] r_o_dist;

    logic [DLP_VW-1:0]        top, head_addr, bd_addr, u_pick;
    logic [EW-1:0]            e_top, head_rd;
    logic signed [DLP_DW-1:0] bd_rd;
    logic                     rd_en;
    logic [EW-1:0]            rd_addr;
    logic                     emit_go, t_in_use, better;
    logic signed [DLP_DW:0]   sum;
    logic signed [DLP_DW-1:0] cand;
    logic [DLP_CW-1:0]        nv_cfg;

    assign top    = DLP_VW'(r_depth - DLP_CW'(1));
    assign e_top  = r_stk_e[top];
    assign u_pick = r_ord[DLP_VW'(r_count - DLP_CW'(1))];

    // Shared read ports on the list heads and the distance table.
    always_comb begin
        case (r_state)
            S_OUTER: head_addr = r_i[DLP_VW-1:0];
            S_EDGE:  head_addr = r_rd_tgt;
            S_RPICK: head_addr = u_pick;
            default: head_addr = i_item.from_v;
        endcase
        case (r_state)
            S_RPICK: bd_addr = u_pick;
            S_EMIT:  bd_addr = r_j[DLP_VW-1:0];
            default: bd_addr = r_rd_tgt;
        endcase
    end
    assign head_rd = r_head[head_addr];
    assign bd_rd   = r_bd[bd_addr];

    // Saturating relaxation candidate.
    assign sum      = $signed({r_du[DLP_DW-1], r_du}) + (DLP_DW+1)'(r_rd_wt);
    assign cand     = (sum > DLP_DIST_MAX) ? DLP_DIST_MAX[DLP_DW-1:0] :
                      (sum < DLP_DIST_MIN) ? DLP_DIST_MIN[DLP_DW-1:0] : sum[DLP_DW-1:0];
    assign t_in_use = ({1'b0, r_rd_tgt} < r_nv);
    assign better   = !r_bv[r_rd_tgt] || (bd_rd < cand);

    assign nv_cfg  = (i_vertex_count == '0) ? DLP_CW'(1) :
                     (i_vertex_count > DLP_CW'(NV)) ? DLP_CW'(NV) : i_vertex_count;
    assign emit_go = !r_ov || i_out_ready;
    assign o_item_ready = (r_state == S_IDLE);

    // Next state and edge store read request.
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = r_e;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && i_item.op == OP_RUN) n_state = S_OUTER;
            end
            S_OUTER: begin
                if (r_i == r_nv) n_state = S_RINIT;
                else if (!r_vis[r_i[DLP_VW-1:0]]) n_state = S_TOP;
            end
            S_TOP: begin
                if (e_top == NIL) begin
                    if (r_depth == DLP_CW'(1)) n_state = S_OUTER;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = e_top;
                    n_state = S_EDGE;
                end
            end
            S_EDGE:  n_state = S_TOP;
            S_RINIT: n_state = S_RPICK;
            S_RPICK: begin
                if (r_count == '0) n_state = S_EMIT;
                else if (r_bv[u_pick]) n_state = S_RWALK;
            end
            S_RWALK: begin
                if (r_e == NIL) begin
                    n_state = S_RPICK;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_RREL;
                end
            end
            S_RREL: n_state = S_RWALK;
            S_EMIT: begin
                if (emit_go && (r_j == r_nv - DLP_CW'(1))) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Edge store write and registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_item_valid && i_item.op == OP_ADD && r_fill != NIL) begin
            m_tgt[r_fill[AW-1:0]] <= i_item.to_v;
            m_wt[r_fill[AW-1:0]]  <= i_item.weight;
            m_lnk[r_fill[AW-1:0]] <= head_rd;
        end
        if (rd_en) begin
            r_rd_tgt <= m_tgt[rd_addr[AW-1:0]];
            r_rd_wt  <= m_wt[rd_addr[AW-1:0]];
            r_rd_lnk <= m_lnk[rd_addr[AW-1:0]];
        end
    end

    // Graph bookkeeping, ordering, relaxation and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) r_head[k] <= NIL;
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && !(r_state == S_EMIT && emit_go)) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        case (i_item.op)
                            OP_ADD: begin
                                if (r_fill == NIL) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_head[i_item.from_v] <= r_fill;
                                    r_fill <= r_fill + EW'(1);
                                end
                            end
                            OP_CLR: begin
                                for (int k = 0; k < NV; k++) r_head[k] <= NIL;
                                r_fill <= '0;
                                r_ovf  <= 1'b0;
                            end
                            OP_RUN: begin
                                r_vis   <= '0;
                                r_i     <= '0;
                                r_count <= '0;
                                r_depth <= '0;
                                r_nv    <= nv_cfg;
                                r_start <= i_item.from_v;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUTER: begin
                    if (r_i != r_nv) begin
                        if (r_vis[r_i[DLP_VW-1:0]]) begin
                            r_i <= r_i + DLP_CW'(1);
                        end else begin
                            r_vis[r_i[DLP_VW-1:0]] <= 1'b1;
                            r_stk_v[0] <= r_i[DLP_VW-1:0];
                            r_stk_e[0] <= head_rd;
                            r_depth    <= DLP_CW'(1);
                        end
                    end
                end
                S_TOP: begin
                    if (e_top == NIL) begin
                        if (r_count != DLP_CW'(NV)) begin
                            r_ord[r_count[DLP_VW-1:0]] <= r_stk_v[top];
                            r_count <= r_count + DLP_CW'(1);
                        end
                        r_depth <= r_depth - DLP_CW'(1);
                        if (r_depth == DLP_CW'(1)) r_i <= r_i + DLP_CW'(1);
                    end
                end
                S_EDGE: begin
                    r_stk_e[top] <= r_rd_lnk;
                    if (t_in_use && !r_vis[r_rd_tgt] && r_depth != DLP_CW'(NV)) begin
                        r_vis[r_rd_tgt] <= 1'b1;
                        r_stk_v[r_depth[DLP_VW-1:0]] <= r_rd_tgt;
                        r_stk_e[r_depth[DLP_VW-1:0]] <= head_rd;
                        r_depth <= r_depth + DLP_CW'(1);
                    end
                end
                S_RINIT: begin
                    r_bv <= ({1'b0, r_start} < r_nv) ? (NV'(1) << r_start) : '0;
                    if ({1'b0, r_start} < r_nv) r_bd[r_start] <= '0;
                end
                S_RPICK: begin
                    if (r_count != '0) begin
                        r_count <= r_count - DLP_CW'(1);
                        r_u  <= u_pick;
                        r_du <= bd_rd;
                        r_e  <= head_rd;
                    end
                end
                S_RREL: begin
                    if (t_in_use && better) begin
                        r_bv[r_rd_tgt] <= 1'b1;
                        r_bd[r_rd_tgt] <= cand;
                        if (r_rd_tgt == r_u) r_du <= cand;
                    end
                    r_e <= r_rd_lnk;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_ov     <= 1'b1;
                        r_o_idx  <= r_j[DLP_VW-1:0];
                        r_o_rch  <= r_bv[r_j[DLP_VW-1:0]];
                        r_o_dist <= r_bv[r_j[DLP_VW-1:0]] ? bd_rd : '0;
                        r_o_drop <= r_ovf;
                        r_o_last <= (r_j == r_nv - DLP_CW'(1));
                        r_j      <= r_j + DLP_CW'(1);
                    end
                end
                default: ;
            endcase
            if (r_state == S_RINIT) r_j <= '0;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_vertex_index  = r_o_idx;
    assign o_reachable     = r_o_rch;
    assign o_distance      = r_o_dist;
    assign o_edges_dropped = r_o_drop;
    assign o_last_result   = r_o_last;

endmodule

// File: hdl/dlp_checker.sv
`include "dag_longest_path_top_macros.svh"

module dlp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [dlp_pkg::DLP_VW-1:0]        o_vertex_index,
    input logic                              o_reachable,
    input logic signed [dlp_pkg::DLP_DW-1:0] o_distance,
    input logic                              o_last_result
);
    // A stalled result stays offered.
    `DLP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid, "result withdrawn while stalled")
    // An unreachable vertex reports zero distance.
    `DLP_ASSERT_IMPL(a_unreach_zero, i_clk, i_rst_n, o_out_valid && !o_reachable, o_distance == '0, "unreachable vertex with nonzero distance")
    // The highest vertex is always the last of its run.
    `DLP_ASSERT_IMPL(a_last_vertex, i_clk, i_rst_n, o_out_valid && !o_last_result, o_vertex_index != 4'd15, "vertex 15 reported without last flag")
endmodule

bind dag_longest_path_top dlp_checker u_chk (.*);
